FILE: src/lpht_pkg.sv
package lpht_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int KEY_BYTES   = 8;

  localparam int KEY_W   = 64;
  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;
  localparam int SLOT_OW = 4;

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int KB_W   = $clog2(KEY_BYTES + 1);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_DELETED  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // One hash step: h * 37 + byte, built from shifts and adds, wrapping at 64 bits.
  function automatic logic [KEY_W-1:0] hash_step(input logic [KEY_W-1:0] h,
                                                 input logic [7:0] b);
    hash_step = (h << 5) + (h << 2) + h + KEY_W'(b);
  endfunction

endpackage

FILE: src/linear_probe_hash_table_core.sv
// Key-value table with open addressing and linear probing.
// Input channel: in_valid_i / in_stall_o carry a request of op_i (insert,
// lookup, delete), key_i (up to eight bytes, first byte least significant,
// ended by the first zero byte) and value_i (stored on insert).
// Output channel: out_valid_o / out_stall_i carry one response per request:
// status_o, value_out_o (stored value on a hit of a lookup, else zero) and
// slot_o (slot written, found or cleared, else zero).
// A request is taken only while the block is idle. The hash unit then takes
// the key one byte at a time up to its end, then probes the table through a
// slot memory with one registered read address, one slot per cycle, stopping
// at the first key match or after all slots, and then commits the result. A
// hit near the home slot ends sooner.
// The response waits in the output register while out_stall_i is high; the
// commit cycle holds until that register is free, and no new request is
// taken before the commit.
// Reset clears all slot valid marks; key and value storage needs no clearing.
module linear_probe_hash_table_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lpht_pkg::OP_W-1:0]       op_i,
  input  logic [lpht_pkg::KEY_W-1:0]      key_i,
  input  logic [lpht_pkg::VALUE_W-1:0]    value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lpht_pkg::STAT_W-1:0]     status_o,
  output logic [lpht_pkg::VALUE_W-1:0]    value_out_o,
  output logic [lpht_pkg::SLOT_OW-1:0]    slot_o
);
  import lpht_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    key_q;
  logic [VALUE_W-1:0]  value_q;
  logic [KEY_W-1:0]    nkey_q;
  logic [KEY_W-1:0]    hash_q;
  logic [KB_W-1:0]     byte_idx_q;

  logic [SLOT_W-1:0]   probe_idx_q;
  logic [CNT_W-1:0]    issue_cnt_q;
  logic                cmp_valid_q;
  logic [SLOT_W-1:0]   cmp_idx_q;
  logic                rd_used_q;
  logic [KEY_W-1:0]    rd_key_q;
  logic [VALUE_W-1:0]  rd_val_q;

  logic                hit_q;
  logic [SLOT_W-1:0]   hit_idx_q;
  logic [VALUE_W-1:0]  hit_val_q;
  logic                empty_q;
  logic [SLOT_W-1:0]   empty_idx_q;

  logic [TABLE_SLOTS-1:0] used_q;
  logic [KEY_W-1:0]       key_mem [TABLE_SLOTS];
  logic [VALUE_W-1:0]     val_mem [TABLE_SLOTS];

  logic                out_valid_q;
  status_e             status_q;
  logic [VALUE_W-1:0]  value_out_q;
  logic [SLOT_OW-1:0]  slot_q;

  logic                in_fire;
  logic                done_fire;
  logic [KEY_W-1:0]    key_sh;
  logic [7:0]          cur_byte;
  logic                hash_end;
  logic [SLOT_W-1:0]   probe_next;
  logic                cmp_hit;
  logic                last_cmp;

  status_e             res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [SLOT_W-1:0]   res_idx;
  logic                res_has_slot;
  logic                we_key;
  logic                we_val;
  logic                set_used;
  logic                clr_used;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign done_fire   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign key_sh   = key_q >> {byte_idx_q, 3'b000};
  assign cur_byte = key_sh[7:0];
  assign hash_end = (byte_idx_q == KB_W'(KEY_BYTES)) || (cur_byte == 8'd0);

  assign probe_next = (probe_idx_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0
                                                                : probe_idx_q + 1'b1;
  assign cmp_hit  = cmp_valid_q && rd_used_q && (rd_key_q == nkey_q);
  assign last_cmp = cmp_valid_q && (issue_cnt_q == CNT_W'(TABLE_SLOTS));

  // Result and table update for the commit cycle.
  always_comb begin
    res_status   = ST_MISSING;
    res_value    = '0;
    res_idx      = hit_idx_q;
    res_has_slot = 1'b0;
    we_key       = 1'b0;
    we_val       = 1'b0;
    set_used     = 1'b0;
    clr_used     = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        if (hit_q) begin
          res_status   = ST_UPDATED;
          res_has_slot = 1'b1;
          we_val       = 1'b1;
        end else if (empty_q) begin
          res_status   = ST_INSERTED;
          res_idx      = empty_idx_q;
          res_has_slot = 1'b1;
          we_key       = 1'b1;
          we_val       = 1'b1;
          set_used     = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (hit_q) begin
          res_status   = ST_FOUND;
          res_value    = hit_val_q;
          res_has_slot = 1'b1;
        end
      end
      OP_DELETE: begin
        if (hit_q) begin
          res_status   = ST_DELETED;
          res_has_slot = 1'b1;
          clr_used     = 1'b1;
        end
      end
      default: begin
        res_status = ST_MISSING;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      key_q       <= '0;
      value_q     <= '0;
      nkey_q      <= '0;
      hash_q      <= '0;
      byte_idx_q  <= '0;
      probe_idx_q <= '0;
      issue_cnt_q <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      rd_used_q   <= 1'b0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_val_q   <= '0;
      empty_q     <= 1'b0;
      empty_idx_q <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_INSERTED;
      value_out_q <= '0;
      slot_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !done_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q       <= op_i;
            key_q      <= key_i;
            value_q    <= value_i;
            nkey_q     <= '0;
            hash_q     <= '0;
            byte_idx_q <= '0;
            state_q    <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_end) begin
            // The slot count is a power of two, so the modulo is a mask.
            probe_idx_q <= SLOT_W'(hash_q % KEY_W'(TABLE_SLOTS));
            issue_cnt_q <= '0;
            cmp_valid_q <= 1'b0;
            hit_q       <= 1'b0;
            empty_q     <= 1'b0;
            state_q     <= S_PROBE;
          end else begin
            hash_q     <= hash_step(hash_q, cur_byte);
            nkey_q     <= nkey_q | (KEY_W'(cur_byte) << {byte_idx_q, 3'b000});
            byte_idx_q <= byte_idx_q + 1'b1;
          end
        end
        S_PROBE: begin
          // Issue one slot read per cycle; compare the slot read last cycle.
          if (issue_cnt_q != CNT_W'(TABLE_SLOTS)) begin
            rd_used_q   <= used_q[probe_idx_q];
            cmp_idx_q   <= probe_idx_q;
            cmp_valid_q <= 1'b1;
            probe_idx_q <= probe_next;
            issue_cnt_q <= issue_cnt_q + 1'b1;
          end else begin
            cmp_valid_q <= 1'b0;
          end
          if (cmp_hit) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cmp_idx_q;
            hit_val_q <= rd_val_q;
            state_q   <= S_DONE;
          end else begin
            if (cmp_valid_q && !rd_used_q && !empty_q) begin
              empty_q     <= 1'b1;
              empty_idx_q <= cmp_idx_q;
            end
            if (last_cmp) begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (done_fire) begin
            if (set_used) begin
              used_q[res_idx] <= 1'b1;
            end
            if (clr_used) begin
              used_q[res_idx] <= 1'b0;
            end
            out_valid_q <= 1'b1;
            status_q    <= res_status;
            value_out_q <= res_value;
            slot_q      <= res_has_slot ? SLOT_OW'(res_idx) : '0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Slot storage: one read address per cycle, written only at commit.
  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[probe_idx_q];
    rd_val_q <= val_mem[probe_idx_q];
    if (done_fire && we_key) begin
      key_mem[res_idx] <= nkey_q;
    end
    if (done_fire && we_val) begin
      val_mem[res_idx] <= value_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_out_q;
  assign slot_o      = slot_q;

  a_accept_starts_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_HASH))
    else $error("accepted request did not start hashing");

  a_value_only_on_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_FOUND)) |-> (value_out_o == '0))
    else $error("nonzero value on a response other than found");

  a_no_slot_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((status_o == ST_MISSING) || (status_o == ST_FULL)))
      |-> (slot_o == '0))
    else $error("slot reported on a miss or full table");

  a_commit_sets_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("commit did not load the response register");

  a_insert_marks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && set_used) |=> (used_q[$past(res_idx)] == 1'b1))
    else $error("inserted slot not marked valid");

endmodule

FILE: dv/linear_probe_hash_table_core_tb.sv
module linear_probe_hash_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  // The block leaves op code 3 unassigned; it must behave as a lookup that misses.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    status_e             status;
    logic [VALUE_W-1:0]  value_out;
    logic [SLOT_OW-1:0]  slot;
  } response_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
    logic                fixed;
    status_e             status;
    logic [VALUE_W-1:0]  value_out;
    logic [SLOT_OW-1:0]  slot;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i = OP_LOOKUP;
  logic [KEY_W-1:0]     key_i = '0;
  logic [VALUE_W-1:0]   value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STAT_W-1:0]    status_o;
  logic [VALUE_W-1:0]   value_out_o;
  logic [SLOT_OW-1:0]   slot_o;

  // Shadow copy of the slot storage.
  logic [KEY_W-1:0]     tbl_key [TABLE_SLOTS];
  logic [VALUE_W-1:0]   tbl_value [TABLE_SLOTS];
  bit                   tbl_used [TABLE_SLOTS];

  response_t            response_q [$];
  response_t            want;
  int                   errors = 0;
  int                   cycles = 0;
  bit                   calm = 1'b0;

  stim_row_t directed_rows [23] = '{
    '{OP_LOOKUP, 64'h0,                   32'h0,         1'b1, ST_MISSING, 32'h0, 4'h0},
    '{OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,         1'b1, ST_MISSING, 32'h0, 4'h0},
    '{OP_UNUSED, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 1'b1, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'h0,                   32'hFFFF_FFFF, 1'b1, ST_INSERTED, 32'h0, 4'h0},
    '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 32'h0,     1'b1, ST_FOUND, 32'hFFFF_FFFF, 4'h0},
    '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,         1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_A5A5, 1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,         1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'h0000_0000_0000_00FF, 32'h0000_0001, 1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'h5A5A_5A5A_5A5A_00FF, 32'h0000_0002, 1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'h01,                  32'h0000_0003, 1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'h11,                  32'h0000_0004, 1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'h21,                  32'h0000_0005, 1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_DELETE, 64'h11,                  32'h0,         1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_LOOKUP, 64'h21,                  32'h0,         1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'h31,                  32'h0000_0006, 1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_UNUSED, 64'h21,                  32'h0,         1'b1, ST_MISSING, 32'h0, 4'h0},
    '{OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,         1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,         1'b1, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'h8080_8080_8080_8080, 32'h8000_0000, 1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 32'h7FFF_FFFF, 1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_LOOKUP, 64'h8080_8080_8080_8080, 32'h0,         1'b0, ST_MISSING, 32'h0, 4'h0},
    '{OP_DELETE, 64'h0,                   32'h0,         1'b1, ST_DELETED, 32'h0, 4'h0}
  };

  linear_probe_hash_table_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .value_out_o (value_out_o),
    .slot_o      (slot_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one request to the shadow table and returns the response it should give.
  function automatic response_t hash_table_op(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] raw,
                                              input logic [VALUE_W-1:0] val);
    logic [KEY_W-1:0] nkey;
    logic [KEY_W-1:0] h;
    logic [7:0]       b;
    bit               ended;
    int               home;
    int               hit;
    int               idx;
    response_t        r;
    nkey = '0;
    h = '0;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = raw[8*i +: 8];
      if (b == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        nkey[8*i +: 8] = b;
        h = h * 64'd37 + KEY_W'(b);
      end
    end
    home = int'(h % TABLE_SLOTS);
    hit = -1;
    if (op != OP_UNUSED) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        idx = (home + i) % TABLE_SLOTS;
        if (hit < 0 && tbl_used[idx] && tbl_key[idx] == nkey) begin
          hit = idx;
        end
      end
    end
    r = '{ST_MISSING, '0, '0};
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          tbl_value[hit] = val;
          r.status = ST_UPDATED;
          r.slot = SLOT_OW'(hit);
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            idx = (home + i) % TABLE_SLOTS;
            if (r.status == ST_FULL && !tbl_used[idx]) begin
              tbl_used[idx] = 1'b1;
              tbl_key[idx] = nkey;
              tbl_value[idx] = val;
              r.status = ST_INSERTED;
              r.slot = SLOT_OW'(idx);
            end
          end
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) begin
          r.status = ST_FOUND;
          r.value_out = tbl_value[hit];
          r.slot = SLOT_OW'(hit);
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          r.status = ST_DELETED;
          r.slot = SLOT_OW'(hit);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // A key of the given number of nonzero bytes.
  function automatic logic [KEY_W-1:0] make_key(input int len);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i < len) begin
        k[8*i +: 8] = 8'($urandom_range(255, 1));
      end
    end
    return k;
  endfunction

  // At random, fills bytes past the terminating zero with junk, which the block must ignore.
  function automatic logic [KEY_W-1:0] dress_key(input logic [KEY_W-1:0] nkey);
    int len;
    bit ended;
    len = 0;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (nkey[8*i +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        len++;
      end
    end
    if (len < 7 && $urandom_range(1) == 1) begin
      return nkey | ({$urandom, $urandom} & (~64'h0 << (8 * (len + 1))));
    end
    return nkey;
  endfunction

  // Entered and left just after a rising edge; returns after the edge that takes the request.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] val, input bit fixed,
                              input response_t fixed_r);
    int        gap;
    bit        taken;
    response_t r;
    gap = 0;
    if (!calm && $urandom_range(99) < 45) begin
      gap = $urandom_range(8, 1);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    key_i <= key;
    value_i <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) begin
        r = hash_table_op(op, key, val);
        response_q.push_back(fixed ? fixed_r : r);
      end
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Outputs settle after the rising edge, so the falling edge sees what the next edge takes.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (response_q.size() == 0) begin
        $display("%0t: unexpected response status %0d value %h slot %0d",
                 $time, status_o, value_out_o, slot_o);
        errors++;
      end else begin
        want = response_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
        if (value_out_o !== want.value_out) begin
          $display("%0t: value_out expected %h actual %h", $time, want.value_out,
                   value_out_o);
          errors++;
        end
        if (slot_o !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, slot_o);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0]   pool [24];
    int                 pool_n;
    int                 ins_pct;
    int                 run_len;
    int                 sent;
    int                 pick;
    int                 idx;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] val;
    response_t          fixed_r;

    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_used[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      fixed_r = '{directed_rows[i].status, directed_rows[i].value_out, directed_rows[i].slot};
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                   directed_rows[i].fixed, fixed_r);
    end

    // Runs over a small key set so that updates, collisions and a full table all occur.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      pool_n = $urandom_range(24, 4);
      for (int k = 0; k < pool_n; k++) begin
        idx = $urandom_range(TABLE_SLOTS - 1);
        if ($urandom_range(1) == 1 && tbl_used[idx]) begin
          pool[k] = tbl_key[idx];
        end else begin
          pool[k] = make_key($urandom_range(KEY_BYTES));
        end
      end
      ins_pct = $urandom_range(80, 30);
      run_len = $urandom_range(80, 20);
      for (int j = 0; j < run_len && sent < RANDOM_REQUESTS; j++) begin
        calm = (sent >= 300 && sent < 420);
        pick = $urandom_range(99);
        if (pick < 4) begin
          op = OP_UNUSED;
        end else if (pick < 4 + ins_pct * 96 / 100) begin
          op = OP_INSERT;
        end else if ($urandom_range(1) == 1) begin
          op = OP_LOOKUP;
        end else begin
          op = OP_DELETE;
        end
        if ($urandom_range(99) < 10) begin
          key = {$urandom, $urandom};
        end else begin
          key = dress_key(pool[$urandom_range(pool_n - 1)]);
        end
        pick = $urandom_range(99);
        if (pick < 5) begin
          val = '0;
        end else if (pick < 10) begin
          val = '1;
        end else begin
          val = $urandom;
        end
        send_request(op, key, val, 1'b0, fixed_r);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (response_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
